// File: rtl/core/sse_pkg.sv
// Shared types and constants for the shot speed and energy calculator.
// No dependencies.
package sse_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAIL,
        ST_TDIV,
        ST_SQ,
        ST_SQ_MUL,
        ST_MASS,
        ST_MASS_MUL,
        ST_SBCD,
        ST_SBCD_CONV,
        ST_EBCD,
        ST_EBCD_CONV,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start_div;
        logic start_tail;
        logic start_sq;
        logic start_mass;
        logic start_sbcd;
        logic start_ebcd;
        logic do_round;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last;
    } t_status;

    localparam logic [1:0] REG_DISTANCE = 2'd0;
    localparam logic [1:0] REG_MASS     = 2'd1;
    localparam logic [3:0] BLANK        = 4'd10;

endpackage

// File: rtl/core/shot_speed_energy_calculator_core.sv
// Top level: result valid when the serial datapath is done; next cycle for a zero or timeout count.
// One request at a time: a new request is taken only once the result has left, so an output stall holds it off.
// Latency is set by the bit-serial dividers, multipliers and BCD converters.
// Synchronous active-low reset clears the controller and both registers.
// Depends on sse_pkg, sse_ctrl, sse_datapath.
module shot_speed_energy_calculator_core #(
    parameter int TIMEOUT_HIGH = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_tick_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [15:0] o_speed_tenths,
    output logic [3:0]  o_speed_digit_a,
    output logic [3:0]  o_speed_digit_b,
    output logic [3:0]  o_speed_digit_c,
    output logic [3:0]  o_speed_digit_d,
    output logic [31:0] o_energy_raw,
    output logic [3:0]  o_energy_digit_a,
    output logic [3:0]  o_energy_digit_b,
    output logic [3:0]  o_energy_digit_c,
    output logic [3:0]  o_energy_digit_d,
    output logic [1:0]  o_energy_point
);
    logic [23:0] r_distance;
    logic [7:0]  r_mass;
    sse_pkg::t_cmd cmd;
    sse_pkg::t_status status;
    logic bad, ok;
    logic [15:0] speed;
    logic [3:0]  sd [4];
    logic [3:0]  ed [4];
    logic [31:0] energy;
    logic [1:0]  point;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance <= '0;
            r_mass     <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sse_pkg::REG_DISTANCE[0]) r_distance <= pwdata[23:0];
            else r_mass <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == sse_pkg::REG_MASS[0]) ? {24'd0, r_mass}
                                                       : {8'd0, r_distance};

    sse_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .i_out_stall(i_stall),
        .o_bad(bad), .i_status(status), .o_cmd(cmd)
    );

    sse_datapath #(.TIMEOUT_HIGH(TIMEOUT_HIGH)) u_dp (
        .i_clk, .i_cmd(cmd), .o_status(status),
        .i_tick_count, .i_distance(r_distance), .i_mass(r_mass),
        .o_speed(speed), .o_sd(sd), .o_energy(energy), .o_ed(ed),
        .o_point(point), .o_ok(ok)
    );

    // Zero every field on a bad count
    assign o_valid_res      = ok && !bad;
    assign o_speed_tenths   = bad ? '0 : speed;
    assign o_speed_digit_a  = bad ? '0 : sd[0];
    assign o_speed_digit_b  = bad ? '0 : sd[1];
    assign o_speed_digit_c  = bad ? '0 : sd[2];
    assign o_speed_digit_d  = bad ? '0 : sd[3];
    assign o_energy_raw     = bad ? '0 : energy;
    assign o_energy_digit_a = bad ? '0 : ed[0];
    assign o_energy_digit_b = bad ? '0 : ed[1];
    assign o_energy_digit_c = bad ? '0 : ed[2];
    assign o_energy_digit_d = bad ? '0 : ed[3];
    assign o_energy_point   = bad ? '0 : point;
endmodule

// File: rtl/core/sse_datapath.sv
// Datapath: serial divider, serial multiplier, double-dabble converters, rounding.
// Depends on sse_pkg.
module sse_datapath #(
    parameter int TIMEOUT_HIGH = 50
) (
    input  logic                 i_clk,
    input  sse_pkg::t_cmd        i_cmd,
    output sse_pkg::t_status     o_status,
    input  logic [23:0]          i_tick_count,
    input  logic [23:0]          i_distance,
    input  logic [7:0]           i_mass,
    output logic [15:0]          o_speed,
    output logic [3:0]           o_sd [4],
    output logic [31:0]          o_energy,
    output logic [3:0]           o_ed [4],
    output logic [1:0]           o_point,
    output logic                 o_ok
);
    localparam logic [1:0] MODE_DIV = 2'd0;
    localparam logic [1:0] MODE_MUL = 2'd1;
    localparam logic [1:0] MODE_BCD = 2'd2;

    logic [23:0] r_ticks, r_quo;
    logic [24:0] r_rem;
    logic [5:0]  r_cnt;
    logic [31:0] r_acc, r_mcand;
    logic [31:0] r_mplier;
    logic [15:0] r_speed;
    logic [31:0] r_energy;
    logic [31:0] r_bin;
    logic [39:0] r_bcd;
    logic [1:0]  r_mode;
    logic        r_ok;
    logic [3:0]  dg [10];
    logic [3:0]  sel_ed [4];
    logic [1:0]  sel_point;
    logic [24:0] rem_sh;
    logic [39:0] bcd_adj;

    assign o_status.bad  = (i_tick_count == 24'd0) ||
                           (i_tick_count[23:16] >= 8'(TIMEOUT_HIGH));
    assign o_status.last = (r_cnt == 6'd0);

    // Shift remainder left by one with the next dividend bit
    assign rem_sh = {r_rem[23:0], r_quo[23]};

    // Add three to every BCD nibble above four
    always_comb begin
        for (int k = 0; k < 10; k++) begin
            bcd_adj[k*4 +: 4] = (r_bcd[k*4 +: 4] > 4'd4) ? r_bcd[k*4 +: 4] + 4'd3
                                                          : r_bcd[k*4 +: 4];
        end
    end

    always_comb begin
        for (int k = 0; k < 10; k++) dg[k] = r_bcd[(9-k)*4 +: 4];
    end

    // Cascaded round-half-down on the energy digits: a digit above five bumps the next more significant digit
    function automatic logic [39:0] bump(input logic [39:0] b, input int k);
        logic [39:0] x;
        logic        c;
        x = b;
        c = 1'b1;
        for (int j = 9; j >= 0; j--) begin
            if (j <= k && c) begin
                if (x[(9-j)*4 +: 4] == 4'd9) x[(9-j)*4 +: 4] = 4'd0;
                else begin
                    x[(9-j)*4 +: 4] = x[(9-j)*4 +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return x;
    endfunction

    function automatic logic [39:0] rnd(input logic [39:0] b, input int k);
        return (b[(9-k)*4 +: 4] > 4'd5) ? bump(b, k - 1) : b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ticks <= i_tick_count;
            r_quo   <= i_distance;
            r_rem   <= '0;
            r_cnt   <= 6'd23;
            r_ok    <= 1'b1;
        end else if (i_cmd.start_tail) begin
            // Divide remainder*10 by ticks: high bits seed the remainder
            r_speed <= 16'(r_quo) * 16'd10;
            r_quo   <= 24'({4'd0, r_rem[23:0]} * 28'd10);
            r_rem   <= 25'(({4'd0, r_rem[23:0]} * 28'd10) >> 24);
            r_cnt   <= 6'd23;
        end else if (i_cmd.start_sq) begin
            r_speed <= r_speed + 16'(r_quo);
            r_acc   <= '0;
            r_mcand <= {16'd0, r_speed + 16'(r_quo)};
            r_mplier <= {16'd0, r_speed + 16'(r_quo)};
            r_cnt   <= 6'd15;
        end else if (i_cmd.start_mass) begin
            r_acc    <= '0;
            r_mcand  <= {1'b0, r_acc[31:1]};
            r_mplier <= {24'd0, i_mass};
            r_cnt    <= 6'd7;
        end else if (i_cmd.start_sbcd) begin
            r_energy <= r_acc;
            r_bin    <= {r_speed, 16'd0};
            r_bcd    <= '0;
            r_cnt    <= 6'd15;
        end else if (i_cmd.start_ebcd) begin
            r_bcd    <= '0;
            r_bin    <= r_energy;
            r_cnt    <= 6'd31;
            // Capture speed digits: thousands, hundreds, tens, ones of tenths
            o_sd[0]  <= (r_bcd[15:12] != 4'd0) ? r_bcd[15:12] : sse_pkg::BLANK;
            o_sd[1]  <= (r_bcd[15:12] != 4'd0 || r_bcd[11:8] != 4'd0) ? r_bcd[11:8]
                                                                   : sse_pkg::BLANK;
            o_sd[2]  <= r_bcd[7:4];
            o_sd[3]  <= r_bcd[3:0];
        end else if (i_cmd.do_round) begin
            r_bcd <= rnd(rnd(rnd(rnd(r_bcd, 9), 8), 7), 6);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 6'd1;
            case (r_mode)
                MODE_DIV: begin
                    // Restoring division step
                    r_quo <= {r_quo[22:0], rem_sh >= {1'b0, r_ticks}};
                    r_rem <= (rem_sh >= {1'b0, r_ticks}) ? rem_sh - {1'b0, r_ticks}
                                                         : rem_sh;
                end
                MODE_MUL: begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= {r_mcand[30:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[31:1]};
                end
                default: begin
                    r_bcd <= {bcd_adj[38:0], r_bin[31]};
                    r_bin <= {r_bin[30:0], 1'b0};
                end
            endcase
        end
    end

    // Datapath operating mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.start_tail) r_mode <= MODE_DIV;
        else if (i_cmd.start_sq || i_cmd.start_mass) r_mode <= MODE_MUL;
        else if (i_cmd.start_sbcd) r_mode <= MODE_BCD;
        else if (i_cmd.start_ebcd) r_mode <= MODE_BCD;
    end

    // Energy digit selection
    always_comb begin
        logic [39:0] b;
        b = r_bcd;
        if (dg[0] != 4'd0) begin
            b = rnd(rnd(b, 5), 4);
            for (int k = 0; k < 4; k++) sel_ed[k] = b[(9-k)*4 +: 4];
            sel_point = 2'd2;
        end else if (dg[1] != 4'd0) begin
            b = rnd(b, 5);
            for (int k = 0; k < 4; k++) sel_ed[k] = b[(8-k)*4 +: 4];
            sel_point = 2'd1;
        end else begin
            for (int k = 0; k < 4; k++) sel_ed[k] = b[(7-k)*4 +: 4];
            sel_point = 2'd0;
        end
    end

    assign o_speed  = r_speed;
    assign o_energy = r_energy;
    assign o_ed     = sel_ed;
    assign o_point  = sel_point;
    assign o_ok     = r_ok;
endmodule

// File: rtl/core/sse_ctrl.sv
// Controller state machine sequencing the datapath.
// Depends on sse_pkg.
module sse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_bad,
    input  sse_pkg::t_status  i_status,
    output sse_pkg::t_cmd     o_cmd
);
    sse_pkg::t_state r_state, n_state;
    logic r_bad, n_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_IDLE;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bad   <= n_bad;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bad       = r_bad;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            sse_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bad      = i_status.bad;
                    n_state    = i_status.bad ? sse_pkg::ST_DONE : sse_pkg::ST_DIV;
                end
            end
            sse_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = sse_pkg::ST_TAIL;
                end
            end
            sse_pkg::ST_TAIL: begin
                o_cmd.start_tail = 1'b1;
                n_state = sse_pkg::ST_TDIV;
            end
            sse_pkg::ST_TDIV: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = sse_pkg::ST_SQ;
            end
            sse_pkg::ST_SQ: begin
                o_cmd.start_sq = 1'b1;
                n_state = sse_pkg::ST_SQ_MUL;
            end
            sse_pkg::ST_SQ_MUL: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = sse_pkg::ST_MASS;
            end
            sse_pkg::ST_MASS: begin
                o_cmd.start_mass = 1'b1;
                n_state = sse_pkg::ST_MASS_MUL;
            end
            sse_pkg::ST_MASS_MUL: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = sse_pkg::ST_SBCD;
            end
            sse_pkg::ST_SBCD: begin
                o_cmd.start_sbcd = 1'b1;
                n_state = sse_pkg::ST_SBCD_CONV;
            end
            sse_pkg::ST_SBCD_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = sse_pkg::ST_EBCD;
            end
            sse_pkg::ST_EBCD: begin
                o_cmd.start_ebcd = 1'b1;
                n_state = sse_pkg::ST_EBCD_CONV;
            end
            sse_pkg::ST_EBCD_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = sse_pkg::ST_ROUND;
            end
            sse_pkg::ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_state = sse_pkg::ST_DONE;
            end
            sse_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = sse_pkg::ST_IDLE;
            end
            default: n_state = sse_pkg::ST_IDLE;
        endcase
    end

    assign o_bad = r_bad;
endmodule

// File: rtl/core/sse_checker.sv
// Port-level checks for the calculator core, bound to the top level.
// Depends on shot_speed_energy_calculator_core.
module sse_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_valid_res,
    input logic [31:0] o_energy_raw
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken while result waits");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_energy_raw == 32'd0) else $error("bad count nonzero");
endmodule

bind shot_speed_energy_calculator_core sse_checker u_chk (.*);
